@@ rtl/mie_pkg.sv @@
// Shared types for the modular inverse block: controller states and the
// status bundle that the serial divider returns. No dependencies.
package mie_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_stat_t;

endpackage

@@ rtl/mie_div.sv @@
// Bit-serial restoring divider with a shift-and-add multiply of the quotient
// by a signed coefficient. Depends on mie_pkg.
module mie_div #(
  parameter int WIDTH = 31
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [WIDTH-1:0]           dividend,
  input  logic [WIDTH-1:0]           divisor,
  input  logic signed [WIDTH+1:0]    coef,
  output logic [WIDTH-1:0]           rem,
  output logic signed [WIDTH+1:0]    prod,
  output mie_pkg::div_stat_t         stat
);
  import mie_pkg::*;

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

  logic               busy;
  logic [CW-1:0]      cnt;
  logic [WIDTH-1:0]   dvd;
  logic [WIDTH-1:0]   dvs;
  logic signed [WIDTH+1:0] mul;
  logic               done;

  logic [WIDTH:0]     rem_sh;
  logic [WIDTH:0]     rem_sub;
  logic               ge;

  // One quotient bit per cycle, most significant first. The product is built
  // in the same order, so it doubles and then takes the coefficient on a one.
  always_comb begin
    rem_sh  = {rem, dvd[WIDTH-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    ge      = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      mul  <= coef;
      rem  <= '0;
      prod <= '0;
    end else if (busy) begin
      dvd  <= {dvd[WIDTH-2:0], 1'b0};
      rem  <= ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      prod <= (prod <<< 1) + (ge ? mul : '0);
    end
  end

  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);

endmodule

@@ rtl/modular_inverse_ext_euclid.sv @@
// Channel   Dir  Fields (lowest bit first)
// s_*       in   tdata: value[WIDTH], modulus[WIDTH], zero pad to bytes
// m_*       out  tdata: inverse[WIDTH], zero pad; tuser: not_invertible
//
// Each Euclid step starts the serial divider, takes its quotient bits one per cycle, waits
// for its done flag and then updates the pairs; the divider's one bit per cycle sets how
// long an item takes from one accept to the next. A zero modulus skips the divider and goes
// straight to the result. No new item is taken while a computation runs.
// Reset is synchronous and clears only control state. A new item is taken
// while the previous result waits on m_tready; the block stalls at the end
// of a computation only if that earlier result is still not taken.
module modular_inverse_ext_euclid #(
  parameter int WIDTH = 31,
  localparam int IN_W  = ((2 * WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // value, modulus, pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // inverse, pad
  output logic             m_tuser    // not_invertible
);
  import mie_pkg::*;

  localparam int TW = WIDTH + 2;

  state_t state, state_next;

  logic [WIDTH-1:0]     r0, r1, modulus;
  logic signed [TW-1:0] t0, t1;
  logic                 mod_zero;

  logic                 div_start;
  logic [WIDTH-1:0]     div_rem;
  logic signed [TW-1:0] div_prod;
  div_stat_t            div_stat;

  logic                 in_acc, out_free;
  logic                 not_inv;
  logic signed [TW-1:0] t_fix;

  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  mie_div #(.WIDTH(WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (r0),
    .divisor  (r1),
    .coef     (t1),
    .rem      (div_rem),
    .prod     (div_prod),
    .stat     (div_stat)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_acc) state_next = ST_START;
      ST_START: state_next = mod_zero ? ST_FIN : ST_DIV;
      ST_DIV:   if (div_stat.done) state_next = ST_UPD;
      ST_UPD:   state_next = div_stat.rem_zero ? ST_FIN : ST_START;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    div_start = (state == ST_START) && !mod_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The pair (value, 1) and (modulus, 0) starts the recurrence, so the first
  // step also reduces the value modulo the modulus.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc) begin
      r0       <= s_tdata[WIDTH-1:0];
      r1       <= s_tdata[2*WIDTH-1:WIDTH];
      modulus  <= s_tdata[2*WIDTH-1:WIDTH];
      mod_zero <= (s_tdata[2*WIDTH-1:WIDTH] == '0);
      t0       <= TW'(1);
      t1       <= '0;
    end else if (state == ST_UPD) begin
      r0 <= r1;
      r1 <= div_rem;
      t0 <= t1;
      t1 <= t0 - div_prod;
    end
  end

  assign not_inv = mod_zero || (r0 != WIDTH'(1));
  assign t_fix   = t0[TW-1] ? (t0 + TW'(modulus)) : t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      m_tdata <= not_inv ? '0 : OUT_W'(t_fix[WIDTH-1:0]);
      m_tuser <= not_inv;
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> r1 != '0)
    else $error("divide started with a zero divisor");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tdata == '0)
    else $error("non-invertible result carries a nonzero inverse");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_START)
    else $error("accepted item did not start a computation");

endmodule

@@ verif/tb_modular_inverse_ext_euclid.sv @@
// Self-checking bench for modular_inverse_ext_euclid: drives value/modulus pairs
// over the input stream and checks every inverse against an extended Euclid predictor.
// Depends on the RTL top level (rtl/modular_inverse_ext_euclid.sv) and, through it, on mie_div and mie_pkg.
module tb_modular_inverse_ext_euclid;

  localparam int WIDTH = 31;
  localparam int IN_W  = ((2 * WIDTH + 7) / 8) * 8;
  localparam int OUT_W = ((WIDTH + 7) / 8) * 8;
  localparam logic [WIDTH-1:0] FIELD_MAX = '1;

  typedef struct {
    bit [WIDTH-1:0] value;
    bit [WIDTH-1:0] modulus;
    bit [WIDTH-1:0] inverse;
    bit             not_inv;
  } inverse_exp_t;

  class inverse_ledger;
    inverse_exp_t pending_inverses[$];
    int mismatches;
    int accepted;
    int non_invertible;

    // Iterative extended Euclid, tracking only the coefficient of the value.
    function void euclid_inverse(input bit [WIDTH-1:0] value, input bit [WIDTH-1:0] modulus,
                                 output bit [WIDTH-1:0] inverse, output bit not_inv);
      longint r0, r1, t0, t1, q, tmp;
      inverse = '0;
      not_inv = 1'b1;
      if (modulus == 0) return;
      r0 = longint'(modulus);
      r1 = longint'(value % modulus);
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
        q   = r0 / r1;
        tmp = r0 - q * r1;
        r0  = r1;
        r1  = tmp;
        tmp = t0 - q * t1;
        t0  = t1;
        t1  = tmp;
      end
      if (r0 != 1) return;
      if (t0 < 0) t0 += longint'(modulus);
      inverse = t0[WIDTH-1:0];
      not_inv = 1'b0;
    endfunction

    function void flag_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function void note_operands(bit [WIDTH-1:0] value, bit [WIDTH-1:0] modulus);
      inverse_exp_t e;
      e.value   = value;
      e.modulus = modulus;
      euclid_inverse(value, modulus, e.inverse, e.not_inv);
      if (e.not_inv) non_invertible++;
      accepted++;
      pending_inverses.insert(pending_inverses.size(), e);
    endfunction

    function void check_result(logic [WIDTH-1:0] inverse, logic not_inv);
      inverse_exp_t e;
      if (pending_inverses.size() == 0) begin
        flag_error($sformatf("result inverse=%0d not_invertible=%0b with no item pending",
                             inverse, not_inv));
        return;
      end
      e = pending_inverses.pop_front();
      if (inverse !== e.inverse || not_inv !== e.not_inv)
        flag_error($sformatf("value=%0d modulus=%0d: inverse exp %0d got %0d, %s",
                             e.value, e.modulus, e.inverse, inverse,
                             $sformatf("not_invertible exp %0b got %0b", e.not_inv, not_inv)));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;   // value, modulus, zero pad
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // inverse, zero pad
  logic             m_tuser;        // not_invertible

  inverse_ledger book = new();
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int long_stall = 0;

  modular_inverse_ext_euclid #(.WIDTH(WIDTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Result side: check accepted items, then pick the next ready. Rare long stalls
  // make the block finish while its previous result is still held.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) book.check_result(m_tdata[WIDTH-1:0], m_tuser);
      if (long_stall > 0) begin
        long_stall <= long_stall - 1;
        m_tready   <= 1'b0;
      end else if (rx_stall_pct > 0 && $urandom_range(3999) == 0) begin
        long_stall <= $urandom_range(200, 3000);
        m_tready   <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_pair(input bit [WIDTH-1:0] value, input bit [WIDTH-1:0] modulus);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    // An occasional long gap lets the next item arrive at any point of a computation.
    if (tx_idle_pct > 0 && $urandom_range(15) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 1600)) @(posedge clk);
    end
    s_tdata  <= IN_W'({modulus, value});
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_operands(value, modulus);
  endtask

  // The last item was taken already, so the sender lets go of tvalid while it waits.
  task automatic wait_drained();
    int cycles;
    cycles = 0;
    s_tvalid <= 1'b0;
    while (book.pending_inverses.size() != 0 && cycles < 20000) begin
      @(posedge clk);
      cycles++;
    end
  endtask

  task automatic pick_operands(output bit [WIDTH-1:0] value, output bit [WIDTH-1:0] modulus);
    longint a, b, c, g;
    int k;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        value   = WIDTH'($urandom());
        modulus = WIDTH'($urandom());
        if (modulus == 0) modulus = WIDTH'(1);
      end
      4: begin
        value   = WIDTH'($urandom());
        modulus = WIDTH'($urandom_range(1, 64));
      end
      5: begin
        // Shared factor, so the pair is never invertible.
        g       = longint'($urandom_range(2, 1000));
        a       = g * $urandom_range(0, FIELD_MAX / g);
        b       = g * $urandom_range(1, FIELD_MAX / g);
        value   = a[WIDTH-1:0];
        modulus = b[WIDTH-1:0];
      end
      6: begin
        // Consecutive Fibonacci numbers give the longest Euclid chains.
        a = 1;
        b = 1;
        k = $urandom_range(1, 44);
        repeat (k) begin
          c = a + b;
          a = b;
          b = c;
        end
        value   = a[WIDTH-1:0];
        modulus = b[WIDTH-1:0];
      end
      7: begin
        value   = WIDTH'($urandom());
        modulus = FIELD_MAX;
      end
      8: begin
        modulus = WIDTH'($urandom_range(1, 1 << 20));
        a       = longint'(modulus) * $urandom_range(1, 2000) + $urandom_range(0, modulus - 1);
        value   = a[WIDTH-1:0];
      end
      default: begin
        case ($urandom_range(2))
          0: value = '0;
          1: value = WIDTH'(1);
          default: value = FIELD_MAX;
        endcase
        case ($urandom_range(3))
          0: modulus = '0;
          1: modulus = WIDTH'(1);
          2: modulus = WIDTH'(2);
          default: modulus = FIELD_MAX;
        endcase
      end
    endcase
  endtask

  initial begin
    bit [WIDTH-1:0] value, modulus;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pair(0, 1);
    send_pair(FIELD_MAX, 1);
    send_pair(0, 0);
    send_pair(5, 0);
    send_pair(FIELD_MAX, 0);
    send_pair(0, 7);
    send_pair(0, FIELD_MAX);
    send_pair(1, FIELD_MAX);
    send_pair(FIELD_MAX - 1, FIELD_MAX);
    send_pair(FIELD_MAX, FIELD_MAX);
    send_pair(FIELD_MAX, 2);
    send_pair(FIELD_MAX - 1, 2);
    send_pair(1, 2);
    send_pair(3, 7);
    send_pair(10, 7);
    send_pair(6, 9);
    send_pair(1134903170, 1836311903);
    send_pair(1836311903, 1134903170);
    send_pair(31'h40000000, 31'h40000001);
    send_pair(31'h2AAAAAAA, 31'h55555555);
    send_pair(31'h55555555, 31'h2AAAAAAA);
    // Hold the sender until every result is back before the random phases.
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 84; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 84; end
        default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
      endcase
      for (int i = 0; i < 100; i++) begin
        pick_operands(value, modulus);
        send_pair(value, modulus);
      end
      wait_drained();
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    wait_drained();
    repeat (100) @(posedge clk);
    if (book.pending_inverses.size() != 0)
      book.flag_error($sformatf("%0d results never arrived", book.pending_inverses.size()));

    $display("Checked %0d items, %0d of them not invertible, over four stream pressure phases",
             book.accepted, book.non_invertible);
    $display("with zero and unit moduli, reduced values and long Fibonacci chains; %0d errors.",
             book.mismatches);
    if (book.mismatches == 0)
      $display("tb_modular_inverse_ext_euclid OK");
    else
      $display("tb_modular_inverse_ext_euclid NOT OK");
    $finish;
  end

  initial begin
    #200000000;
    $display("tb_modular_inverse_ext_euclid NOT OK");
    $finish;
  end

endmodule
